[sv/dhat_pkg.sv]
// dhat_pkg: shared types, codes and constants for the anchor table block.
// No dependencies; imported by every module of the block.
package dhat_pkg;

    localparam int DEF_SLOTS = 4;
    localparam int SQ_STEPS  = 17;   // result bits of the distance root

    localparam logic [1:0] OP_BEACON  = 2'd0;
    localparam logic [1:0] OP_NOTICE  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_IMPROVED = 3'd2;
    localparam logic [2:0] ST_SIZE     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_COMPUTED = 3'd5;
    localparam logic [2:0] ST_NOHOPS   = 3'd6;

    localparam logic [1:0] REG_OWN_ID  = 2'd0;
    localparam logic [1:0] REG_OWN_X   = 2'd1;
    localparam logic [1:0] REG_OWN_Y   = 2'd2;
    localparam logic [1:0] REG_SINK_ID = 2'd3;

    typedef struct packed {
        logic load;       // latch input transaction, clear accumulators
        logic idx_clr;
        logic idx_inc;
        logic rd;         // read slot at index into read registers
        logic mark_hit;
        logic diff;       // abs differences to own position
        logic mul;        // squares
        logic sq_start;
        logic sq_step;
        logic acc;        // add root and hops to sums
        logic div_start;
        logic div_step;
        logic emit;       // commit table update and load output register
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_end;
        logic       hit;
        logic       sq_done;
        logic       div_done;
        logic       hop_zero;
        logic       out_free;
    } sts_t;

endpackage

[sv/dv_hop_anchor_table.sv]
// DV-Hop anchor table: one transaction in, one result transaction out.
// Beacon/notice: search the stored slots in order (slot read, id compare).
// Compute: per stored anchor, root of the squared distance added to sums; then distance sum / hop sum.
// One transaction at a time; the next is taken while a result waits in the output register.
// rst_n is asynchronous, active low: table empty, config at own_id=1, sink_id=1, x=y=0.
// Depends on dhat_pkg, dhat_ctrl, dhat_dp.
module dv_hop_anchor_table
    import dhat_pkg::*;
#(
    parameter int ANCHOR_SLOTS = DEF_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // anchor_id, anchor_x, anchor_y, beacon hops, hop_size,
                                   // sender_address
    input  logic [1:0]  s_tuser,   // operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // forward, rebroadcast hops, avg_hop_size,
                                   // table_complete, zero pad
    output logic [2:0]  m_tuser,   // status
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // config is always taken and lands at once; write only with no transaction in flight
    assign cfg_ready = 1'b1;

    dhat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dhat_dp #(
        .SLOTS (ANCHOR_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_op      (s_tuser),
        .in_data    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

[sv/dhat_ctrl.sv]
// dhat_ctrl: sequencer for search, distance root, division and result issue.
// Depends on dhat_pkg; drives dhat_dp through cmd_t, observes sts_t.
module dhat_ctrl
    import dhat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_LOOK, S_CMP, S_DIFF, S_MUL, S_SQS, S_SQ, S_ACC, S_DIV, S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.op == OP_BEACON || sts.op == OP_NOTICE || sts.op == OP_COMPUTE)
                    state_next = S_LOOK;
                else
                    state_next = S_DONE;
            end
            S_LOOK:
            begin
                if (sts.idx_end)
                begin
                    if (sts.op == OP_COMPUTE && !sts.hop_zero)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = (sts.op == OP_COMPUTE) ? S_DIFF : S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.mark_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd.sq_start = 1'b1;
                state_next   = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (sts.sq_done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc     = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_LOOK;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/dhat_dp.sv]
// dhat_dp: anchor slot memory, config registers, root and divide units, output register.
// Depends on dhat_pkg; sequenced by dhat_ctrl.
module dhat_dp
    import dhat_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  in_op,
    input  logic [79:0] in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_status,
    output logic [31:0] out_data
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int DSW  = SQ_STEPS + CNTW;
    localparam int HSW  = 8 + CNTW;
    localparam int DCW  = $clog2(DSW + 1);

    // config
    logic [7:0]  own_id_reg, sink_id_reg;
    logic [15:0] own_x_reg, own_y_reg;

    // latched transaction
    logic [1:0]  op_reg;
    logic [7:0]  id_reg, hops_reg;
    logic [15:0] ax_reg, ay_reg, size_reg, sender_reg;

    // slot memory
    logic [7:0]  mem_id   [SLOTS];
    logic [15:0] mem_x    [SLOTS];
    logic [15:0] mem_y    [SLOTS];
    logic [7:0]  mem_hops [SLOTS];
    logic [15:0] mem_size [SLOTS];
    logic [7:0]  rd_id_reg, rd_hops_reg;
    logic [15:0] rd_x_reg, rd_y_reg;

    logic [CNTW-1:0] count_reg, idx_reg;
    logic            hit_reg;
    logic [15:0]     next_hop_reg;
    logic [7:0]      sink_hops_reg;

    // distance and division
    logic [15:0]     dx_reg, dy_reg;
    logic [31:0]     sqx_reg, sqy_reg;
    logic [33:0]     sq_v_reg;
    logic [20:0]     sq_rem_reg;
    logic [16:0]     sq_root_reg;
    logic [4:0]      sq_cnt_reg;
    logic [DSW-1:0]  dist_sum_reg, q_reg;
    logic [HSW-1:0]  hop_sum_reg, dv_rem_reg;
    logic [DCW-1:0]  dv_cnt_reg;

    logic            out_valid_reg;
    logic [2:0]      out_status_reg;
    logic [31:0]     out_data_reg;

    logic [20:0]     rem_sh, trial;
    logic [HSW:0]    dv_sh;
    logic [2:0]      status;
    logic            wr_ins, wr_hops, wr_size, full;
    logic [15:0]     avg;
    logic [7:0]      fwd_hops;
    logic [CNTW-1:0] count_next;

    assign full = (count_reg == CNTW'(SLOTS));

    assign sts.op       = op_reg;
    assign sts.idx_end  = (idx_reg == count_reg);
    assign sts.hit      = (rd_id_reg == id_reg) && (id_reg != 8'd0);
    assign sts.sq_done  = (sq_cnt_reg == 5'(SQ_STEPS - 1));
    assign sts.div_done = (dv_cnt_reg == DCW'(DSW - 1));
    assign sts.hop_zero = (hop_sum_reg == '0);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign rem_sh = {sq_rem_reg[18:0], sq_v_reg[33:32]};
    assign trial  = {2'b00, sq_root_reg, 2'b01};
    assign dv_sh  = {dv_rem_reg, q_reg[DSW-1]};

    always_comb
    begin
        status  = ST_IGNORED;
        wr_ins  = 1'b0;
        wr_hops = 1'b0;
        wr_size = 1'b0;
        avg     = 16'd0;
        case (op_reg)
            OP_BEACON:
            begin
                if (hit_reg)
                begin
                    if (hops_reg < rd_hops_reg)
                    begin
                        status  = ST_IMPROVED;
                        wr_hops = 1'b1;
                    end
                end
                else if (id_reg != 8'd0 && id_reg != own_id_reg)
                begin
                    if (full)
                        status = ST_FULL;
                    else
                    begin
                        status = ST_INSERTED;
                        wr_ins = 1'b1;
                    end
                end
            end
            OP_NOTICE:
            begin
                if (hit_reg)
                begin
                    status  = ST_SIZE;
                    wr_size = 1'b1;
                end
            end
            OP_COMPUTE:
            begin
                if (hop_sum_reg == '0)
                    status = ST_NOHOPS;
                else
                begin
                    status = ST_COMPUTED;
                    avg    = (|q_reg[DSW-1:16]) ? 16'hFFFF : q_reg[15:0];
                end
            end
            default: status = ST_IGNORED;
        endcase
        fwd_hops   = (hops_reg == 8'hFF) ? 8'hFF : hops_reg + 8'd1;
        count_next = wr_ins ? count_reg + CNTW'(1) : count_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= 8'd1;
            own_x_reg     <= 16'd0;
            own_y_reg     <= 16'd0;
            sink_id_reg   <= 8'd1;
            count_reg     <= '0;
            next_hop_reg  <= 16'd0;
            sink_hops_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_OWN_ID:  own_id_reg  <= cfg_data[7:0];
                    REG_OWN_X:   own_x_reg   <= cfg_data;
                    REG_OWN_Y:   own_y_reg   <= cfg_data;
                    REG_SINK_ID: sink_id_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.emit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                if ((status == ST_INSERTED || status == ST_IMPROVED) && id_reg == sink_id_reg)
                begin
                    next_hop_reg  <= sender_reg;
                    sink_hops_reg <= hops_reg;
                end
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= in_op;
            id_reg       <= in_data[7:0];
            ax_reg       <= in_data[23:8];
            ay_reg       <= in_data[39:24];
            hops_reg     <= in_data[47:40];
            size_reg     <= in_data[63:48];
            sender_reg   <= in_data[79:64];
            hit_reg      <= 1'b0;
            dist_sum_reg <= '0;
            hop_sum_reg  <= '0;
        end
        if (cmd.idx_clr)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + CNTW'(1);
        if (cmd.mark_hit)
            hit_reg <= 1'b1;
        if (cmd.rd)
        begin
            rd_id_reg   <= mem_id[idx_reg[IDXW-1:0]];
            rd_x_reg    <= mem_x[idx_reg[IDXW-1:0]];
            rd_y_reg    <= mem_y[idx_reg[IDXW-1:0]];
            rd_hops_reg <= mem_hops[idx_reg[IDXW-1:0]];
        end
        if (cmd.diff)
        begin
            dx_reg <= (own_x_reg >= rd_x_reg) ? own_x_reg - rd_x_reg : rd_x_reg - own_x_reg;
            dy_reg <= (own_y_reg >= rd_y_reg) ? own_y_reg - rd_y_reg : rd_y_reg - own_y_reg;
        end
        if (cmd.mul)
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
        end
        if (cmd.sq_start)
        begin
            sq_v_reg    <= {1'b0, {1'b0, sqx_reg} + {1'b0, sqy_reg}};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= '0;
        end
        else if (cmd.sq_step)
        begin
            sq_v_reg   <= {sq_v_reg[31:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + 5'd1;
            if (rem_sh >= trial)
            begin
                sq_rem_reg  <= rem_sh - trial;
                sq_root_reg <= {sq_root_reg[15:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= rem_sh;
                sq_root_reg <= {sq_root_reg[15:0], 1'b0};
            end
        end
        if (cmd.acc)
        begin
            dist_sum_reg <= dist_sum_reg + DSW'(sq_root_reg);
            hop_sum_reg  <= hop_sum_reg + HSW'(rd_hops_reg);
        end
        if (cmd.div_start)
        begin
            q_reg      <= dist_sum_reg;
            dv_rem_reg <= '0;
            dv_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dv_cnt_reg <= dv_cnt_reg + DCW'(1);
            if (dv_sh >= {1'b0, hop_sum_reg})
            begin
                dv_rem_reg <= HSW'(dv_sh - {1'b0, hop_sum_reg});
                q_reg      <= {q_reg[DSW-2:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_sh[HSW-1:0];
                q_reg      <= {q_reg[DSW-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            out_status_reg <= status;
            out_data_reg   <= {6'd0, full || wr_ins && count_next == CNTW'(SLOTS), avg,
                               (wr_ins || wr_hops) ? fwd_hops : 8'd0,
                               wr_ins || wr_hops || wr_size};
        end
    end

    // slot memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.emit && wr_ins)
        begin
            mem_id[idx_reg[IDXW-1:0]]   <= id_reg;
            mem_x[idx_reg[IDXW-1:0]]    <= ax_reg;
            mem_y[idx_reg[IDXW-1:0]]    <= ay_reg;
            mem_hops[idx_reg[IDXW-1:0]] <= hops_reg;
            mem_size[idx_reg[IDXW-1:0]] <= size_reg;
        end
        if (cmd.emit && wr_hops)
            mem_hops[idx_reg[IDXW-1:0]] <= hops_reg;
        if (cmd.emit && wr_size)
            mem_size[idx_reg[IDXW-1:0]] <= size_reg;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;

endmodule
